>>> rtl/fcc_pkg.sv
`default_nettype none
package fcc_pkg;
    localparam int MAX_SPAN_DEF  = 4096;
    localparam int MAX_CELLS_DEF = 16777216;
    localparam int CELL_W  = 24;
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 24;
    localparam int SX_W    = 13;
    localparam int SZ_W    = 7;
    localparam int IDX_W   = 3;
    localparam int NTERM   = 12;
    localparam int ACC_W   = 72;

    localparam logic [IDX_W-1:0] REG_STRIDE_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_STRIDE_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_STRIDE_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_WLO      = 3'd3;
    localparam logic [IDX_W-1:0] REG_WUP      = 3'd4;
    localparam logic [IDX_W-1:0] REG_NORM     = 3'd5;

    localparam logic [1:0] CLS_PLAIN = 2'd0;
    localparam logic [1:0] CLS_LOWER = 2'd1;
    localparam logic [1:0] CLS_UPPER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_ACC, ST_SITE, ST_NORM, ST_OUT
    } back_state_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_idx;
        logic              emit;
        logic [DATA_W-1:0] prev_value;
        logic [DATA_W-1:0] site_weight;
    } job_t;
endpackage
`default_nettype wire

>>> rtl/fcc_if.sv
`default_nettype none
interface fcc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] prev_value;
    logic [31:0] site_weight;
    logic        grid_start;
    modport source (output valid, prev_value, site_weight, grid_start, input ready);
    modport sink (input valid, prev_value, site_weight, grid_start, output ready);
endinterface

interface fcc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_value;
    logic [23:0] out_cell;
    logic        saturated;
    modport source (output valid, out_value, out_cell, saturated, input ready);
    modport sink (input valid, out_value, out_cell, saturated, output ready);
endinterface

interface fcc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/fcc_ram.sv
`default_nettype none
module fcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/fcc_front.sv
`default_nettype none
module fcc_front #(
    parameter int MAX_CELLS = fcc_pkg::MAX_CELLS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          grid_start,
    input  wire logic [fcc_pkg::DATA_W-1:0]    prev_value,
    input  wire logic [fcc_pkg::DATA_W-1:0]    site_weight,
    input  wire logic                          q_full,
    input  wire logic [fcc_pkg::SX_W:0]        span,
    output logic                               push,
    output fcc_pkg::job_t                      job
);
    logic [fcc_pkg::CELL_W-1:0] cnt_reg;
    logic [fcc_pkg::CELL_W-1:0] cnt_next;
    logic [fcc_pkg::CELL_W-1:0] n;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;
    assign n        = grid_start ? '0 : cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push)
        begin
            if ({8'd0, n} == 32'(MAX_CELLS - 1))
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = n + 1'b1;
            end
        end
    end

    assign job.emit        = n >= fcc_pkg::CELL_W'(span);
    assign job.cell_idx    = n - fcc_pkg::CELL_W'(span);
    assign job.prev_value  = prev_value;
    assign job.site_weight = site_weight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

>>> rtl/fcc_back.sv
`default_nettype none
module fcc_back #(
    parameter int MAX_SPAN = fcc_pkg::MAX_SPAN_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    input  wire fcc_pkg::job_t             q_job,
    output logic                           q_pop,
    input  wire logic [fcc_pkg::SX_W-1:0]  sx,
    input  wire logic [fcc_pkg::SX_W-1:0]  sy,
    input  wire logic [fcc_pkg::SZ_W-1:0]  sz,
    input  wire logic [31:0]               wlo,
    input  wire logic [31:0]               wup,
    input  wire logic [31:0]               norm,
    output logic [$clog2(2*MAX_SPAN)-1:0]  v_raddr,
    input  wire logic [31:0]               v_rdata,
    output logic [$clog2(MAX_SPAN)-1:0]    w_raddr,
    input  wire logic [31:0]               w_rdata,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [31:0]                    out_value,
    output logic [23:0]                    out_cell,
    output logic                           saturated
);
    localparam int VAW = $clog2(2*MAX_SPAN);
    localparam int WAW = $clog2(MAX_SPAN);
    localparam int CW  = fcc_pkg::CELL_W;
    localparam int AW  = fcc_pkg::ACC_W;

    fcc_pkg::back_state_t state_reg, state_next;
    logic [3:0]    term_reg, term_next;
    logic [CW-1:0] cell_reg;
    logic [AW-1:0] acc_reg;
    logic [1:0]    cls_reg;
    logic          live_reg;
    logic [1:0]    part_reg;
    logic [63:0]   prod_reg;
    logic [AW-1:0] r_reg;
    logic [31:0]   mulb_reg;
    logic [31:0]   val_reg;
    logic          vld_reg;
    logic          sat_reg;
    logic [CW-1:0] ocell_reg;

    logic [CW-1:0] ta, tb;
    logic [1:0]    tcls;
    logic [CW-1:0] xy, yz, xz;
    logic [31:0]   mula;
    logic [AW-1:0] shifted;

    assign xy = CW'(sx) + CW'(sy);
    assign yz = CW'(sy) + CW'(sz);
    assign xz = CW'(sx) + CW'(sz);

    always_comb
    begin
        ta = '0;
        tb = '0;
        tcls = fcc_pkg::CLS_PLAIN;
        case (term_reg)
            4'd0: ta = xy;
            4'd1: tb = xy;
            4'd2: begin ta = CW'(sx); tb = CW'(sy); end
            4'd3: begin ta = CW'(sy); tb = CW'(sx); end
            4'd4: begin ta = yz; tcls = fcc_pkg::CLS_LOWER; end
            4'd5: begin ta = CW'(sz); tb = CW'(sy); tcls = fcc_pkg::CLS_LOWER; end
            4'd6: begin ta = xz; tcls = fcc_pkg::CLS_LOWER; end
            4'd7: begin ta = CW'(sz); tb = CW'(sx); tcls = fcc_pkg::CLS_LOWER; end
            4'd8: begin tb = yz; tcls = fcc_pkg::CLS_UPPER; end
            4'd9: begin ta = CW'(sy); tb = CW'(sz); tcls = fcc_pkg::CLS_UPPER; end
            4'd10: begin tb = xz; tcls = fcc_pkg::CLS_UPPER; end
            4'd11: begin ta = CW'(sx); tb = CW'(sz); tcls = fcc_pkg::CLS_UPPER; end
            default: ta = '0;
        endcase
    end

    assign v_raddr = VAW'(cell_reg - ta + tb);
    assign w_raddr = WAW'(cell_reg);

    // Multiplicand chunk: low word then high word of the wide operand.
    assign mula = (part_reg == 2'd0) ? r_reg[31:0] : r_reg[63:32];
    assign shifted = AW'((prod_reg + 64'd8388608) >> fcc_pkg::FRAC_W);

    assign q_pop     = (state_reg == fcc_pkg::ST_IDLE) && q_valid
                       && !(vld_reg && !out_ready);
    assign out_valid = vld_reg;
    assign out_value = val_reg;
    assign out_cell  = ocell_reg;
    assign saturated = sat_reg;

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        case (state_reg)
            fcc_pkg::ST_IDLE:
            begin
                if (q_pop && q_job.emit)
                begin
                    state_next = fcc_pkg::ST_READ;
                    term_next  = '0;
                end
            end
            fcc_pkg::ST_READ: state_next = fcc_pkg::ST_MUL;
            fcc_pkg::ST_MUL:  state_next = fcc_pkg::ST_ACC;
            fcc_pkg::ST_ACC:
            begin
                if (term_reg == 4'(fcc_pkg::NTERM - 1))
                begin
                    state_next = fcc_pkg::ST_SITE;
                end
                else
                begin
                    term_next  = term_reg + 1'b1;
                    state_next = fcc_pkg::ST_READ;
                end
            end
            fcc_pkg::ST_SITE:
            begin
                if (part_reg == 2'd3)
                begin
                    state_next = fcc_pkg::ST_NORM;
                end
            end
            fcc_pkg::ST_NORM:
            begin
                if (part_reg == 2'd3)
                begin
                    state_next = fcc_pkg::ST_OUT;
                end
            end
            fcc_pkg::ST_OUT:
            begin
                if (!vld_reg || out_ready)
                begin
                    state_next = fcc_pkg::ST_IDLE;
                end
            end
            default: state_next = fcc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcc_pkg::ST_IDLE;
            term_reg  <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            if (state_reg == fcc_pkg::ST_OUT && (!vld_reg || out_ready))
            begin
                vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

    // Wide products: low 64 bits of the 72-bit operand split into two 32-bit halves, one per pass.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            fcc_pkg::ST_IDLE:
            begin
                cell_reg <= q_job.cell_idx;
                acc_reg  <= '0;
                part_reg <= '0;
            end
            fcc_pkg::ST_READ:
            begin
                cls_reg  <= tcls;
                live_reg <= cell_reg >= ta;
            end
            fcc_pkg::ST_MUL:
            begin
                prod_reg <= 64'(v_rdata) * 64'((cls_reg == fcc_pkg::CLS_LOWER) ? wlo : wup);
            end
            fcc_pkg::ST_ACC:
            begin
                if (live_reg)
                begin
                    if (cls_reg == fcc_pkg::CLS_PLAIN)
                    begin
                        acc_reg <= acc_reg + AW'(v_rdata);
                    end
                    else
                    begin
                        acc_reg <= acc_reg + shifted;
                    end
                end
                if (term_reg == 4'(fcc_pkg::NTERM - 1))
                begin
                    r_reg <= (live_reg ? ((cls_reg == fcc_pkg::CLS_PLAIN)
                             ? acc_reg + AW'(v_rdata) : acc_reg + shifted) : acc_reg);
                    mulb_reg <= w_rdata;
                    part_reg <= '0;
                end
            end
            fcc_pkg::ST_SITE, fcc_pkg::ST_NORM:
            begin
                part_reg <= part_reg + 1'b1;
                case (part_reg)
                    2'd0: prod_reg <= 64'(mula) * 64'(mulb_reg);
                    2'd1:
                    begin
                        acc_reg  <= shifted;
                        prod_reg <= 64'(mula) * 64'(mulb_reg);
                    end
                    2'd2:
                    begin
                        acc_reg <= acc_reg + AW'({prod_reg, 8'd0});
                    end
                    default:
                    begin
                        r_reg    <= acc_reg;
                        mulb_reg <= norm;
                    end
                endcase
            end
            fcc_pkg::ST_OUT:
            begin
                if (!vld_reg || out_ready)
                begin
                    sat_reg   <= |r_reg[AW-1:32];
                    val_reg   <= (|r_reg[AW-1:32]) ? 32'hFFFFFFFF : r_reg[31:0];
                    ocell_reg <= cell_reg;
                end
            end
            default: part_reg <= '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == fcc_pkg::ST_IDLE) else $error("pop while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !out_ready) |=> $stable(val_reg) && $stable(ocell_reg))
        else $error("result changed while held");
    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        term_reg < 4'(fcc_pkg::NTERM)) else $error("term index out of range");
`endif
endmodule
`default_nettype wire

>>> rtl/fcc_lattice_propagator_stencil.sv
`default_nettype none
// FCC 12-neighbor stencil propagator. Cells stream in linear order; the front
// end numbers each cell and queues it with its data, and the back end writes
// the cell into the value and weight ring memories when it takes the job, so
// the rings never run ahead of the cell being computed. A result for cell
// m = n - D follows once D = max(sx+sy, sy+sz, sx+sz) further cells exist.
// The back end handles one job at a time: it takes the job, makes twelve
// neighbor reads (read, multiply, accumulate) on the single value-ring read
// port, runs two wide multiplies and loads the result; cells that emit
// nothing pass at one per cycle while the job queue has room and the back
// end is idle. A result waiting on the output holds back the next job. The
// value ring holds 2*MAX_SPAN entries; it is not cleared, since no term
// reaches below cell 0. Configuration must be written only while idle.
module fcc_lattice_propagator_stencil #(
    parameter int MAX_SPAN  = fcc_pkg::MAX_SPAN_DEF,
    parameter int MAX_CELLS = fcc_pkg::MAX_CELLS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fcc_in_if.sink      in_ch,
    fcc_out_if.source   out_ch,
    fcc_cfg_if.sink     cfg
);
    localparam int VAW = $clog2(2*MAX_SPAN);
    localparam int WAW = $clog2(MAX_SPAN);
    localparam int QD  = 4;

    logic [12:0] sx_reg, sy_reg;
    logic [6:0]  sz_reg;
    logic [31:0] wlo_reg, wup_reg, norm_reg;
    logic [13:0] span;
    logic [13:0] xy, yz, xz;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg   <= 13'd1;
            sy_reg   <= 13'd1;
            sz_reg   <= 7'd1;
            wlo_reg  <= 32'd16777216;
            wup_reg  <= 32'd16777216;
            norm_reg <= 32'd1398101;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                fcc_pkg::REG_STRIDE_X: sx_reg <= cfg.data[12:0];
                fcc_pkg::REG_STRIDE_Y: sy_reg <= cfg.data[12:0];
                fcc_pkg::REG_STRIDE_Z: sz_reg <= cfg.data[6:0];
                fcc_pkg::REG_WLO:      wlo_reg <= cfg.data;
                fcc_pkg::REG_WUP:      wup_reg <= cfg.data;
                fcc_pkg::REG_NORM:     norm_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign xy = 14'(sx_reg) + 14'(sy_reg);
    assign yz = 14'(sy_reg) + 14'(sz_reg);
    assign xz = 14'(sx_reg) + 14'(sz_reg);
    always_comb
    begin
        span = xy;
        if (yz > span) span = yz;
        if (xz > span) span = xz;
    end

    logic          push, pop, q_full, q_valid;
    fcc_pkg::job_t job, q_job;
    fcc_pkg::job_t q_mem [QD];
    logic [2:0]    q_cnt_reg;
    logic [1:0]    q_wr_reg, q_rd_reg;

    fcc_front #(.MAX_CELLS(MAX_CELLS)) u_front (
        .clk, .rst_n,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .grid_start(in_ch.grid_start),
        .prev_value(in_ch.prev_value), .site_weight(in_ch.site_weight),
        .q_full, .span, .push, .job
    );

    assign q_full  = q_cnt_reg == 3'(QD);
    assign q_valid = q_cnt_reg != 3'd0;
    assign q_job   = q_mem[q_rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[q_wr_reg] <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_reg + 3'(push) - 3'(pop);
            if (push) q_wr_reg <= q_wr_reg + 1'b1;
            if (pop)  q_rd_reg <= q_rd_reg + 1'b1;
        end
    end

    logic [VAW-1:0] v_raddr;
    logic [WAW-1:0] w_raddr;
    logic [31:0]    v_rdata, w_rdata;
    logic [fcc_pkg::CELL_W-1:0] n_in;

    assign n_in = q_job.cell_idx + fcc_pkg::CELL_W'(span);

    fcc_ram #(.WIDTH(32), .DEPTH(2*MAX_SPAN)) u_vram (
        .clk, .we(pop), .waddr(VAW'(n_in)), .wdata(q_job.prev_value),
        .raddr(v_raddr), .rdata(v_rdata)
    );
    fcc_ram #(.WIDTH(32), .DEPTH(MAX_SPAN)) u_wram (
        .clk, .we(pop), .waddr(WAW'(n_in)), .wdata(q_job.site_weight),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    fcc_back #(.MAX_SPAN(MAX_SPAN)) u_back (
        .clk, .rst_n, .q_valid, .q_job, .q_pop(pop),
        .sx(sx_reg), .sy(sy_reg), .sz(sz_reg),
        .wlo(wlo_reg), .wup(wup_reg), .norm(norm_reg),
        .v_raddr, .v_rdata, .w_raddr, .w_rdata,
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_value(out_ch.out_value), .out_cell(out_ch.out_cell),
        .saturated(out_ch.saturated)
    );

`ifndef ASSERT_OFF
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= 3'(QD)) else $error("job queue overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid) else $error("pop from empty queue");
`endif
endmodule
`default_nettype wire
